// File: hdl/epd_pkg.sv
// Package for the escaped packet deframer: byte codes, state type and
// the command/status bundles between controller and datapath.
// No dependencies.
package epd_pkg;

   // Default depth of the frame content store
   localparam int CONTENT_DEPTH_DEFAULT = 64;

   // Escape byte and the codes that may follow it
   localparam logic [7:0] ESC_BYTE     = 8'h5c;
   localparam logic [7:0] CODE_START   = 8'h01;
   localparam logic [7:0] CODE_END     = 8'h02;
   localparam logic [7:0] CODE_LITERAL = 8'h03;

   // Stored bytes around the payload: id, size, checksum
   localparam logic [1:0] FRAME_OVERHEAD = 2'd3;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SHOW
   } epd_state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic store_en;       // store a byte in the content store
      logic store_literal;  // stored byte is the escape byte itself
      logic clear_count;    // drop frame content
      logic start_emit;     // begin output of the accepted frame
      logic read_en;        // read the payload byte at the current index
      logic next_index;     // step to the next payload byte
   } epd_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic is_esc;
      logic is_start;
      logic is_end;
      logic is_literal;
      logic frame_ok;       // stored frame passes length and checksum test
      logic size_zero;      // stored payload size is zero
      logic last_item;      // current output item is the final one
   } epd_stat_type;

endpackage

// File: hdl/epd_if.sv
// Handshake channel interfaces for the deframer: byte input and result output.
// Uses nothing from the package.
interface epd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface epd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] packet_id;
   logic [5:0] packet_size;
   logic [5:0] byte_index;
   logic [7:0] payload_byte;
   logic       has_byte;
   logic       last;

   modport source (output valid, output packet_id, output packet_size,
                   output byte_index, output payload_byte, output has_byte,
                   output last, input ready);
   modport sink   (input valid, input packet_id, input packet_size,
                   input byte_index, input payload_byte, input has_byte,
                   input last, output ready);
endinterface

// File: hdl/epd_datapath.sv
// Datapath of the deframer: content store, count, running checksum,
// frame header registers and the output index. Depends on epd_pkg.
module epd_datapath
   import epd_pkg::*;
#(
   parameter int CONTENT_DEPTH = CONTENT_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [7:0]   rx_byte,
   input  epd_cmd_type  cmd,
   output epd_stat_type stat,
   output logic [7:0]   packet_id,
   output logic [5:0]   packet_size,
   output logic [5:0]   byte_index,
   output logic [7:0]   payload_byte,
   output logic         has_byte,
   output logic         last
);

   localparam int AW    = $clog2(CONTENT_DEPTH);
   localparam int CW    = $clog2(CONTENT_DEPTH + 1);
   localparam int CMP_W = (CW > 9) ? CW : 9;
   localparam int SUM_W = (AW > 9) ? AW : 9;

   logic [7:0]    content_mem [CONTENT_DEPTH];
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    xor_ff, xor_in;
   logic [7:0]    id_ff;
   logic [7:0]    size_ff;
   logic [7:0]    idx_ff;
   logic          empty_ff;
   logic [7:0]    rd_data_ff;

   logic          full;
   logic          wr_en;
   logic [7:0]    wr_data;
   logic [SUM_W-1:0] rd_sum;
   logic [AW-1:0] rd_addr;
   logic [8:0]    idx_next;

   // Byte to store and whether there is room for it
   assign full    = (count_ff == CW'(CONTENT_DEPTH));
   assign wr_en   = cmd.store_en && !full;
   assign wr_data = cmd.store_literal ? ESC_BYTE : rx_byte;

   // Count and running XOR of everything stored after id and size;
   // a good frame leaves this XOR at zero (payload XOR equals checksum)
   always_comb begin
      count_in = count_ff;
      xor_in   = xor_ff;
      if (cmd.clear_count) begin
         count_in = '0;
         xor_in   = '0;
      end else if (wr_en) begin
         count_in = count_ff + CW'(1);
         if (count_ff >= CW'(2)) begin
            xor_in = xor_ff ^ wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         xor_ff   <= '0;
      end else begin
         count_ff <= count_in;
         xor_ff   <= xor_in;
      end
   end

   // Content store and header copies
   always_ff @(posedge clock) begin
      if (wr_en) begin
         content_mem[count_ff[AW-1:0]] <= wr_data;
         if (count_ff == CW'(0)) begin
            id_ff <= wr_data;
         end
         if (count_ff == CW'(1)) begin
            size_ff <= wr_data;
         end
      end
   end

   // Payload read port: byte index plus two header bytes
   assign rd_sum  = SUM_W'(idx_ff) + SUM_W'(2);
   assign rd_addr = rd_sum[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.read_en) begin
         rd_data_ff <= content_mem[rd_addr];
      end
   end

   // Output index
   always_ff @(posedge clock) begin
      if (cmd.start_emit) begin
         idx_ff   <= '0;
         empty_ff <= (size_ff == 8'h00);
      end else if (cmd.next_index) begin
         idx_ff <= idx_ff + 8'd1;
      end
   end

   assign idx_next = {1'b0, idx_ff} + 9'd1;

   // Status
   always_comb begin
      stat.is_esc     = (rx_byte == ESC_BYTE);
      stat.is_start   = (rx_byte == CODE_START);
      stat.is_end     = (rx_byte == CODE_END);
      stat.is_literal = (rx_byte == CODE_LITERAL);
      stat.frame_ok   = (CMP_W'(count_ff) >= CMP_W'(FRAME_OVERHEAD))
                     && (CMP_W'(count_ff) == CMP_W'(size_ff) + CMP_W'(FRAME_OVERHEAD))
                     && (xor_ff == 8'h00);
      stat.size_zero  = (size_ff == 8'h00);
      stat.last_item  = empty_ff || (idx_next == {1'b0, size_ff});
   end

   // Result fields
   assign packet_id    = id_ff;
   assign packet_size  = size_ff[5:0];
   assign byte_index   = idx_ff[5:0];
   assign payload_byte = empty_ff ? 8'h00 : rd_data_ff;
   assign has_byte     = !empty_ff;
   assign last         = stat.last_item;

endmodule

// File: hdl/epd_ctrl.sv
// Controller of the deframer: escape and frame tracking, and the
// result output sequence. Depends on epd_pkg.
module epd_ctrl
   import epd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  epd_stat_type stat,
   output epd_cmd_type  cmd
);

   epd_state_type state_ff, state_in;
   logic          esc_ff, esc_in;
   logic          in_frame_ff, in_frame_in;

   // Next state
   always_comb begin
      state_in    = state_ff;
      esc_in      = esc_ff;
      in_frame_in = in_frame_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (stat.is_esc) begin
                  esc_in = 1'b1;
               end else if (esc_ff) begin
                  esc_in = 1'b0;
                  if (stat.is_start) begin
                     in_frame_in = 1'b1;
                  end else if (stat.is_end) begin
                     in_frame_in = 1'b0;
                     if (stat.frame_ok) begin
                        state_in = stat.size_zero ? ST_SHOW : ST_READ;
                     end
                  end
               end
            end
         end
         ST_READ: begin
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_ready) begin
               state_in = stat.last_item ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath commands
   always_comb begin
      cmd       = '0;
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_SHOW);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !stat.is_esc) begin
               if (esc_ff) begin
                  if (stat.is_start) begin
                     cmd.clear_count = 1'b1;
                  end else if (stat.is_end) begin
                     cmd.clear_count = 1'b1;
                     cmd.start_emit  = stat.frame_ok;
                  end else if (stat.is_literal) begin
                     cmd.store_en      = in_frame_ff;
                     cmd.store_literal = 1'b1;
                  end
               end else begin
                  cmd.store_en = in_frame_ff;
               end
            end
         end
         ST_READ: begin
            cmd.read_en = 1'b1;
         end
         ST_SHOW: begin
            cmd.next_index = rsp_ready && !stat.last_item;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         esc_ff      <= 1'b0;
         in_frame_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         esc_ff      <= esc_in;
         in_frame_ff <= in_frame_in;
      end
   end

endmodule

// File: hdl/escaped_packet_deframer_unit.sv
// Top level of the escaped packet deframer: controller plus datapath.
// Depends on epd_pkg, epd_req_if, epd_rsp_if, epd_ctrl and epd_datapath.
//
//   channel   role    payload                                        handshake
//   req_chan  input   rx_byte                                        valid/ready
//   rsp_chan  output  packet_id packet_size byte_index payload_byte  valid/ready
//                     has_byte last
//
// Every received byte is taken while no frame is being output.
// An accepted frame with N payload bytes gives N items, each a store read
// and then the item on the output, or one item for an empty payload;
// input is held off until the last item is taken.
// Synchronous reset clears escape, frame and count state; no clearing pass.
// A stall on the result side holds the current item and the input.
module escaped_packet_deframer_unit
   import epd_pkg::*;
#(
   parameter int CONTENT_DEPTH = CONTENT_DEPTH_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   epd_req_if.sink   req_chan,
   epd_rsp_if.source rsp_chan
);

   epd_cmd_type  cmd;
   epd_stat_type stat;

   epd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   epd_datapath #(
      .CONTENT_DEPTH (CONTENT_DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .rx_byte      (req_chan.rx_byte),
      .cmd          (cmd),
      .stat         (stat),
      .packet_id    (rsp_chan.packet_id),
      .packet_size  (rsp_chan.packet_size),
      .byte_index   (rsp_chan.byte_index),
      .payload_byte (rsp_chan.payload_byte),
      .has_byte     (rsp_chan.has_byte),
      .last         (rsp_chan.last)
   );

   // Input is never taken while a result is offered
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("input ready while a result is offered");

   // After the final item of a frame the block returns to taking input
   a_last_release: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && rsp_chan.last |=> req_chan.ready)
      else $error("input not released after final item");

   // An item without a byte is the single, final item of an empty frame
   a_empty_item: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.has_byte |->
         rsp_chan.last && (rsp_chan.payload_byte == 8'h00))
      else $error("empty item not final or carries a byte");

   // A taken item that is not final is followed by a store read cycle
   a_read_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && !rsp_chan.last |=> !rsp_chan.valid)
      else $error("next item shown without a store read");

endmodule

// File: sim/escaped_packet_deframer_unit_test.sv
// Self-checking bench for escaped_packet_deframer_unit: drives stuffed byte frames,
// predicts the emitted packet items and compares them as they are taken.
// Depends on epd_pkg, epd_req_if, epd_rsp_if and escaped_packet_deframer_unit from the hdl folder.
module escaped_packet_deframer_unit_test
   import epd_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int BYTE_GOAL      = 360;

   // One emitted packet item, at the widths of the result channel
   typedef struct packed {
      logic [7:0] id;
      logic [5:0] size;
      logic [5:0] index;
      logic [7:0] data;
      logic       has_byte;
      logic       last;
   } packet_item_type;

   // Ways a generated frame may be shaped
   typedef enum {
      FR_GOOD,
      FR_BAD_SUM,
      FR_BAD_LEN,
      FR_CUT,
      FR_FLOOD
   } frame_kind_type;

   // Tracks the deframer state and holds the packet items still awaited
   class deframe_tracker;
      bit              esc_seen;
      bit              framing;
      logic [7:0]      content [CONTENT_DEPTH_DEFAULT];
      int unsigned     fill;
      packet_item_type awaited [$];
      int unsigned     failures;
      int unsigned     checked;

      function new();
         esc_seen = 0;
         framing  = 0;
         fill     = 0;
         failures = 0;
         checked  = 0;
      endfunction

      function void save_byte(logic [7:0] b);
         if (fill < CONTENT_DEPTH_DEFAULT) begin
            content[fill] = b;
            fill++;
         end
      endfunction

      // Length and checksum test, then one item per payload byte, or one for an empty payload
      function void close_frame();
         int unsigned     n;
         int unsigned     sz;
         logic [7:0]      sum;
         packet_item_type it;
         n = fill;
         if (n < int'(FRAME_OVERHEAD)) return;
         sz = content[1];
         if (n != sz + int'(FRAME_OVERHEAD)) return;
         sum = 8'h00;
         for (int i = 0; i < sz; i++) sum ^= content[2 + i];
         if (sum != content[n - 1]) return;
         it.id = content[0];
         if (sz == 0) begin
            it.size     = '0;
            it.index    = '0;
            it.data     = '0;
            it.has_byte = 1'b0;
            it.last     = 1'b1;
            awaited.push_back(it);
         end else begin
            for (int i = 0; i < sz; i++) begin
               it.size     = sz[5:0];
               it.index    = i[5:0];
               it.data     = content[2 + i];
               it.has_byte = 1'b1;
               it.last     = (i + 1 == sz);
               awaited.push_back(it);
            end
         end
      endfunction

      // Accepted input byte
      function void take_byte(logic [7:0] b);
         if (b == ESC_BYTE) begin
            esc_seen = 1;
            return;
         end
         if (esc_seen) begin
            if (b == CODE_START) begin
               framing = 1;
               fill    = 0;
            end else if (b == CODE_END) begin
               close_frame();
               framing = 0;
               fill    = 0;
            end else if (b == CODE_LITERAL) begin
               if (framing) save_byte(ESC_BYTE);
            end
            esc_seen = 0;
         end else if (framing) begin
            save_byte(b);
         end
      endfunction

      function void report(string what);
         failures++;
         if (failures <= 10) $display("%s", what);
      endfunction

      // Accepted result item against the oldest awaited one
      function void check_item(packet_item_type got);
         packet_item_type want;
         if (awaited.size() == 0) begin
            report($sformatf("unexpected item: id=%02h size=%0d idx=%0d data=%02h has=%b last=%b",
                             got.id, got.size, got.index, got.data, got.has_byte, got.last));
            return;
         end
         want = awaited.pop_front();
         checked++;
         if (got.id !== want.id || got.size !== want.size || got.index !== want.index ||
             got.data !== want.data || got.has_byte !== want.has_byte ||
             got.last !== want.last)
            report($sformatf({"mismatch: want id=%02h size=%0d idx=%0d data=%02h has=%b last=%b",
                              " got id=%02h size=%0d idx=%0d data=%02h has=%b last=%b"},
                             want.id, want.size, want.index, want.data, want.has_byte,
                             want.last, got.id, got.size, got.index, got.data, got.has_byte,
                             got.last));
      endfunction
   endclass

   logic clock;
   logic reset;

   epd_req_if req_chan ();
   epd_rsp_if rsp_chan ();

   escaped_packet_deframer_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   deframe_tracker tracker;
   logic [7:0]     line_q [$];
   bit             steady;
   int unsigned    bytes_sent;
   int unsigned    items_seen;
   int unsigned    packets_seen;
   int unsigned    quiet_cycles;
   int unsigned    big_frames;

   // Clock
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Result side: random stalls except in the steady stretch
   always @(negedge clock) begin
      rsp_chan.ready <= steady || ($urandom_range(0, 99) >= 32);
   end

   // Monitor: feed the tracker, check items, watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            tracker.take_byte(req_chan.rx_byte);
            quiet_cycles <= 0;
         end else if (rsp_chan.valid && rsp_chan.ready) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            tracker.check_item({rsp_chan.packet_id, rsp_chan.packet_size, rsp_chan.byte_index,
                                rsp_chan.payload_byte, rsp_chan.has_byte, rsp_chan.last});
            items_seen++;
            if (rsp_chan.last) packets_seen++;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("escaped_packet_deframer_unit_test: errors");
            $finish;
         end
      end
   end

   // One byte on the input channel, with random idle cycles in front
   task automatic send_byte(logic [7:0] b);
      while (!steady && $urandom_range(0, 99) < 32) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.rx_byte <= b;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      bytes_sent++;
      steady = (bytes_sent >= 150 && bytes_sent < 230);
   endtask

   task automatic send_line();
      foreach (line_q[i]) send_byte(line_q[i]);
      line_q.delete();
   endtask

   // Frame content byte, escaped when it equals the escape byte
   function automatic void stuff(logic [7:0] b);
      if (b == ESC_BYTE) begin
         line_q.push_back(ESC_BYTE);
         line_q.push_back(CODE_LITERAL);
      end else begin
         line_q.push_back(b);
      end
   endfunction

   function automatic logic [7:0] odd_code();
      logic [7:0] c;
      c = 8'($urandom_range(4, 255));
      if (c == ESC_BYTE) c = 8'h00;
      return c;
   endfunction

   // Builds one stuffed frame of the given shape into the line queue
   task automatic build_frame(logic [7:0] id, int sz, frame_kind_type kind);
      logic [7:0] sum;
      logic [7:0] b;
      logic [7:0] size_field;
      sum        = 8'h00;
      size_field = sz[7:0];
      if (kind == FR_BAD_LEN)
         size_field = $urandom_range(0, 1) ? size_field + 8'd1 : 8'($urandom_range(0, 255));
      line_q.push_back(ESC_BYTE);
      if ($urandom_range(0, 7) == 0) line_q.push_back(ESC_BYTE);
      line_q.push_back(CODE_START);
      stuff(id);
      stuff(size_field);
      for (int i = 0; i < sz; i++) begin
         b = ($urandom_range(0, 9) == 0) ? ESC_BYTE : 8'($urandom_range(0, 255));
         sum ^= b;
         stuff(b);
         // unknown escape code inside the payload is dropped
         if ($urandom_range(0, 15) == 0) begin
            line_q.push_back(ESC_BYTE);
            line_q.push_back(odd_code());
         end
      end
      if (kind == FR_BAD_SUM) sum ^= 8'(1 << $urandom_range(0, 7));
      stuff(sum);
      if (kind == FR_FLOOD)
         repeat ($urandom_range(1, 8)) stuff(8'($urandom_range(0, 255)));
      if (kind != FR_CUT) begin
         line_q.push_back(ESC_BYTE);
         line_q.push_back(CODE_END);
      end
   endtask

   // Stimulus
   initial begin
      int choice;
      tracker          = new();
      steady           = 0;
      bytes_sent       = 0;
      items_seen       = 0;
      packets_seen     = 0;
      quiet_cycles     = 0;
      big_frames       = 0;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = 8'h00;
      rsp_chan.ready   = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: end and literal outside a frame
      line_q = '{ESC_BYTE, CODE_END, ESC_BYTE, CODE_LITERAL};
      send_line();
      // Double escape before start, literal escape in payload, unknown code dropped
      line_q = '{ESC_BYTE, ESC_BYTE, CODE_START, 8'hff, 8'h02, ESC_BYTE, CODE_LITERAL,
                 8'h00, ESC_BYTE, 8'h07, ESC_BYTE, CODE_LITERAL, ESC_BYTE, CODE_END};
      send_line();
      // Start inside a frame restarts it; the new frame has an empty payload
      line_q = '{ESC_BYTE, CODE_START, 8'h11, 8'h22, ESC_BYTE, CODE_START,
                 8'h00, 8'h00, 8'h00, ESC_BYTE, CODE_END};
      send_line();

      // Random frames, broken frames and line noise
      while (bytes_sent < BYTE_GOAL) begin
         choice = $urandom_range(0, 99);
         if (choice < 66) begin
            build_frame(8'($urandom_range(0, 255)), $urandom_range(0, 9), FR_GOOD);
         end else if (choice < 76) begin
            build_frame(8'($urandom_range(0, 255)), $urandom_range(0, 9),
                        frame_kind_type'($urandom_range(int'(FR_BAD_SUM), int'(FR_CUT))));
         end else if (choice < 86) begin
            repeat ($urandom_range(1, 4)) line_q.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) begin
               line_q.push_back(ESC_BYTE);
               line_q.push_back($urandom_range(0, 1) ? CODE_END : CODE_LITERAL);
            end
         end else if (choice < 93 && big_frames < 3) begin
            // Full store; flooding bytes past the checksum are dropped
            big_frames++;
            build_frame(8'($urandom_range(0, 255)), 61,
                        $urandom_range(0, 1) ? FR_FLOOD : FR_GOOD);
         end else begin
            build_frame(8'($urandom_range(0, 255)), $urandom_range(0, 9), FR_FLOOD);
         end
         send_line();
      end
      req_chan.valid <= 1'b0;

      // Drain, then give the block time to show any stray item
      while (tracker.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.awaited.size() != 0)
         tracker.report($sformatf("%0d items never arrived", tracker.awaited.size()));
      $display("run covered %0d input bytes, %0d accepted packets, %0d items (%0d checked)",
               bytes_sent, packets_seen, items_seen, tracker.checked);
      $display("failures counted: %0d", tracker.failures);
      if (tracker.failures == 0)
         $display("escaped_packet_deframer_unit_test: clean");
      else
         $display("escaped_packet_deframer_unit_test: errors");
      $finish;
   end

endmodule

// File: escaped_packet_deframer_unit.f
hdl/epd_pkg.sv
hdl/epd_if.sv
hdl/epd_datapath.sv
hdl/epd_ctrl.sv
hdl/escaped_packet_deframer_unit.sv
sim/escaped_packet_deframer_unit_test.sv
